// ----- rtl/geared_multiturn_angle_tracker_top_defines.svh -----
// ---------------------------------------------------------------------------
// geared multi-turn angle tracker assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef GEARED_MULTITURN_ANGLE_TRACKER_TOP_DEFINES_SVH
`define GEARED_MULTITURN_ANGLE_TRACKER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GMAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define GMAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/gmat_pkg.sv -----
// ---------------------------------------------------------------------------
// gmat_pkg
// widths, reset values, register indexes and shared types of the tracker
// ---------------------------------------------------------------------------
package gmat_pkg;

  // encoder and gearing limits
  localparam int COUNTS_PER_TURN = 16384;
  localparam int MAX_RATIO       = 64;

  // field widths
  localparam int RAW_W      = $clog2(COUNTS_PER_TURN);
  localparam int TURN_W     = $clog2(MAX_RATIO);
  localparam int EXT_W      = RAW_W + TURN_W;
  localparam int RATIO_W    = 7;
  localparam int RECIP_W    = 17;
  localparam int OFFS_W     = 16;
  localparam int SHAFT_W    = 17;
  localparam int REL_W      = 18;
  localparam int ROLL_W     = 2;
  localparam int PROD_W     = EXT_W + RECIP_W;
  localparam int SCALE_SH   = OFFS_W - RAW_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 80;

  // register reset values
  localparam logic [RATIO_W-1:0] RATIO_RST = RATIO_W'(1);
  localparam logic [RECIP_W-1:0] RECIP_RST = RECIP_W'(65536);
  localparam logic [RAW_W-1:0]   LOWER_RST = RAW_W'(4096);
  localparam logic [RAW_W-1:0]   UPPER_RST = RAW_W'(12288);

  // half turn in 1/65536-turn units
  localparam logic signed [REL_W:0] HALF_TURN = (REL_W+1)'(32768);
  localparam logic signed [REL_W:0] FULL_TURN = (REL_W+1)'(65536);

  // rollover codes
  localparam logic [ROLL_W-1:0] ROLL_NONE = 2'b00;
  localparam logic [ROLL_W-1:0] ROLL_FWD  = 2'b01;
  localparam logic [ROLL_W-1:0] ROLL_BWD  = 2'b11;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATIO = 3'd0,
    CFG_RECIP = 3'd1,
    CFG_LOWER = 3'd2,
    CFG_UPPER = 3'd3,
    CFG_SHIFT = 3'd4,
    CFG_ZERO  = 3'd5
  } cfg_idx_e;

  // configuration register set
  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [RECIP_W-1:0] recip;
    logic [RAW_W-1:0]   lower;
    logic [RAW_W-1:0]   upper;
    logic [OFFS_W-1:0]  shift;
    logic [OFFS_W-1:0]  zero;
  } cfg_regs_t;

  // result of one comparator lane
  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_t;

  // item leaving the turn counting stage
  typedef struct packed {
    logic [RAW_W-1:0]  raw;
    logic [TURN_W-1:0] turn;
    logic              bypass;
    logic [ROLL_W-1:0] roll;
    logic              seen;
  } turn_item_t;

endpackage

// ----- rtl/gmat_cmp_lane.sv -----
// ---------------------------------------------------------------------------
// gmat_cmp_lane
// one comparator lane: orders a pair of raw samples
// ---------------------------------------------------------------------------
module gmat_cmp_lane (
  input  logic [gmat_pkg::RAW_W-1:0] x,
  input  logic [gmat_pkg::RAW_W-1:0] y,
  output gmat_pkg::cmp_t             res
);
  import gmat_pkg::*;

  // strict orderings, equal gives neither
  assign res.lt = (x < y);
  assign res.gt = (x > y);

endmodule

// ----- rtl/gmat_median_merge.sv -----
// ---------------------------------------------------------------------------
// gmat_median_merge
// combines the three lane orderings into the selected raw angle
// ---------------------------------------------------------------------------
module gmat_median_merge (
  input  logic [gmat_pkg::RAW_W-1:0] a,
  input  logic [gmat_pkg::RAW_W-1:0] b,
  input  logic [gmat_pkg::RAW_W-1:0] c,
  input  gmat_pkg::cmp_t             ab,
  input  gmat_pkg::cmp_t             ac,
  input  gmat_pkg::cmp_t             bc,
  input  logic                       use_median,
  output logic [gmat_pkg::RAW_W-1:0] raw
);
  import gmat_pkg::*;

  logic [RAW_W-1:0] lo;
  logic [RAW_W-1:0] hi;
  logic             c_le_lo;
  logic             c_ge_hi;
  logic [RAW_W-1:0] med;

  // min and max of a and b, then place c against them
  always_comb begin
    lo      = ab.lt ? a : b;
    hi      = ab.lt ? b : a;
    c_le_lo = ab.lt ? !ac.lt : !bc.lt;
    c_ge_hi = ab.lt ? !bc.gt : !ac.gt;
    if (c_le_lo) begin
      med = lo;
    end else if (c_ge_hi) begin
      med = hi;
    end else begin
      med = c;
    end
    raw = use_median ? med : a;
  end

endmodule

// ----- rtl/gmat_turn_core.sv -----
// ---------------------------------------------------------------------------
// gmat_turn_core
// median lanes, rollover detection, turn counter and sticky flag
// ---------------------------------------------------------------------------
module gmat_turn_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [gmat_pkg::RAW_W-1:0] sample_a,
  input  logic [gmat_pkg::RAW_W-1:0] sample_b,
  input  logic [gmat_pkg::RAW_W-1:0] sample_c,
  input  logic                       use_median,
  input  logic                       clear_rollover,
  input  gmat_pkg::cfg_regs_t        cfg,
  output gmat_pkg::turn_item_t       item
);
  import gmat_pkg::*;

  localparam int N_W = TURN_W + 2;

  cmp_t              lane_ab;
  cmp_t              lane_ac;
  cmp_t              lane_bc;
  logic [RAW_W-1:0]  raw;
  logic [RATIO_W-1:0] ratio_eff;
  logic              bypass;
  logic [ROLL_W-1:0] roll;
  logic signed [N_W-1:0] n;
  logic signed [N_W-1:0] ratio_s;
  logic [TURN_W-1:0] turn_next;
  logic              seen;
  logic              sticky_next;

  logic [RAW_W-1:0]  previous_raw;
  logic [TURN_W-1:0] turn_counter;
  logic              rollover_sticky;

  // comparator lanes over the three sample pairs
  gmat_cmp_lane u_lane_ab (.x(sample_a), .y(sample_b), .res(lane_ab));
  gmat_cmp_lane u_lane_ac (.x(sample_a), .y(sample_c), .res(lane_ac));
  gmat_cmp_lane u_lane_bc (.x(sample_b), .y(sample_c), .res(lane_bc));

  gmat_median_merge u_merge (
    .a          (sample_a),
    .b          (sample_b),
    .c          (sample_c),
    .ab         (lane_ab),
    .ac         (lane_ac),
    .bc         (lane_bc),
    .use_median (use_median),
    .raw        (raw)
  );

  // effective ratio: zero means one, large values saturate
  always_comb begin
    if (cfg.ratio == '0) begin
      ratio_eff = RATIO_W'(1);
    end else if (cfg.ratio > RATIO_W'(MAX_RATIO)) begin
      ratio_eff = RATIO_W'(MAX_RATIO);
    end else begin
      ratio_eff = cfg.ratio;
    end
    bypass = (ratio_eff == RATIO_W'(1));
  end

  // wrap detection, backward test first
  always_comb begin
    roll = ROLL_NONE;
    if (!bypass) begin
      if (previous_raw <= cfg.lower && raw >= cfg.upper) begin
        roll = ROLL_BWD;
      end else if (previous_raw >= cfg.upper && raw <= cfg.lower) begin
        roll = ROLL_FWD;
      end
    end
  end

  // counter step modulo the ratio, also pulls back an oversized count
  always_comb begin
    n       = $signed({2'b00, turn_counter}) + $signed({{(N_W-ROLL_W){roll[ROLL_W-1]}}, roll});
    ratio_s = $signed(N_W'(ratio_eff));
    if (bypass) begin
      turn_next = turn_counter;
    end else if (n >= ratio_s) begin
      turn_next = '0;
    end else if (n < 0) begin
      turn_next = TURN_W'(ratio_eff - RATIO_W'(1));
    end else begin
      turn_next = n[TURN_W-1:0];
    end
    seen        = rollover_sticky | (roll != ROLL_NONE);
    sticky_next = clear_rollover ? 1'b0 : seen;
  end

  // tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw    <= '0;
      turn_counter    <= '0;
      rollover_sticky <= 1'b0;
    end else if (load) begin
      previous_raw    <= raw;
      turn_counter    <= turn_next;
      rollover_sticky <= sticky_next;
    end
  end

  // stage register towards the scaler
  always_ff @(posedge clk) begin
    if (load) begin
      item.raw    <= raw;
      item.turn   <= turn_next;
      item.bypass <= bypass;
      item.roll   <= roll;
      item.seen   <= seen;
    end
  end

endmodule

// ----- rtl/gmat_scale.sv -----
// ---------------------------------------------------------------------------
// gmat_scale
// scales the extended count to shaft angle and applies the offsets
// ---------------------------------------------------------------------------
module gmat_scale (
  input  logic                          clk,
  input  logic                          load_mul,
  input  logic                          load_out,
  input  gmat_pkg::turn_item_t          item,
  input  gmat_pkg::cfg_regs_t           cfg,
  output logic [gmat_pkg::OUT_DATA_W-1:0] result
);
  import gmat_pkg::*;

  localparam int SCL_W = PROD_W - RAW_W;

  logic [EXT_W-1:0]  ext;
  turn_item_t        item_m;
  logic [EXT_W-1:0]  ext_m;
  logic [PROD_W-1:0] prod;
  logic [SCL_W-1:0]  scl_full;
  logic [OFFS_W-1:0] scaled;
  logic signed [SHAFT_W-1:0] shaft;
  logic signed [REL_W:0]     rel_d;
  logic signed [REL_W:0]     rel_f;

  // extended count, turn index ignored in bypass
  assign ext = item.bypass ? {{TURN_W{1'b0}}, item.raw} : {item.turn, item.raw};

  // multiply stage
  always_ff @(posedge clk) begin
    if (load_mul) begin
      item_m <= item;
      ext_m  <= ext;
      prod   <= PROD_W'(ext) * PROD_W'(cfg.recip);
    end
  end

  // scale, saturate, subtract offsets and fold around half a turn
  always_comb begin
    scl_full = prod[PROD_W-1:RAW_W];
    if (item_m.bypass) begin
      scaled = {item_m.raw, {SCALE_SH{1'b0}}};
    end else if (scl_full[SCL_W-1:OFFS_W] != '0) begin
      scaled = '1;
    end else begin
      scaled = scl_full[OFFS_W-1:0];
    end
    shaft = $signed({1'b0, scaled}) - $signed({1'b0, cfg.shift});
    rel_d = $signed({{(REL_W+1-SHAFT_W){shaft[SHAFT_W-1]}}, shaft})
            - $signed({3'b000, cfg.zero});
    rel_f = (rel_d >= HALF_TURN) ? (rel_d - FULL_TURN) : rel_d;
  end

  // output register, fields listed from the highest bit down
  always_ff @(posedge clk) begin
    if (load_out) begin
      result <= {2'b00, item_m.seen, item_m.roll, rel_f[REL_W-1:0], shaft,
                 ext_m, item_m.turn, item_m.raw};
    end
  end

endmodule

// ----- rtl/geared_multiturn_angle_tracker_top.sv -----
// ---------------------------------------------------------------------------
// geared_multiturn_angle_tracker_top
// multi-turn geared encoder tracker with median pre-selection
// ---------------------------------------------------------------------------
//  port group  | dir | transfer when             | contents
//  s_t*        | in  | s_tvalid && s_tready      | three samples, median select, clear
//  m_t*        | out | m_tvalid && m_tready      | angles, turn index, rollover flags
//  cfg_*       | in  | cfg_wr_en                 | register index and data
//
//  one item per cycle unless m_tready stalls; m_tvalid is the registered valid of the last stage
//  stages: median lanes and turn counter, multiplier, offsets into output register
//  each stage moves on when the next is empty or moving, so input stays open
//  while a finished result waits until the two stages behind it are full
//  the turn counter loop closes in the first stage
//  synchronous reset clears valids and tracking state and sets the configuration registers to defaults
// ---------------------------------------------------------------------------
module geared_multiturn_angle_tracker_top (
  input  logic                            clk,
  input  logic                            rst,
  // sample_a, sample_b, sample_c, use_median, clear_rollover, zero pad
  input  logic [gmat_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // raw_angle, turn_index, extended_count, shaft_angle, relative_angle,
  // rollover_direction, rollover_seen, zero pad
  output logic [gmat_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_wr_en,
  input  logic [gmat_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [gmat_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import gmat_pkg::*;

  cfg_regs_t  cfg;
  turn_item_t item;
  logic       v1;
  logic       v2;
  logic       v3;
  logic       rdy1;
  logic       rdy2;
  logic       rdy3;
  logic       accept;
  logic       load_mul;
  logic       load_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ratio <= RATIO_RST;
      cfg.recip <= RECIP_RST;
      cfg.lower <= LOWER_RST;
      cfg.upper <= UPPER_RST;
      cfg.shift <= '0;
      cfg.zero  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_e'(cfg_addr))
        CFG_RATIO: cfg.ratio <= cfg_wdata[RATIO_W-1:0];
        CFG_RECIP: cfg.recip <= cfg_wdata[RECIP_W-1:0];
        CFG_LOWER: cfg.lower <= cfg_wdata[RAW_W-1:0];
        CFG_UPPER: cfg.upper <= cfg_wdata[RAW_W-1:0];
        CFG_SHIFT: cfg.shift <= cfg_wdata[OFFS_W-1:0];
        CFG_ZERO:  cfg.zero  <= cfg_wdata[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  // stage flow control
  assign rdy3     = !v3 || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign accept   = s_tvalid && s_tready;
  assign load_mul = v1 && rdy2;
  assign load_out = v2 && rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  assign m_tvalid = v3;

  gmat_turn_core u_core (
    .clk            (clk),
    .rst            (rst),
    .load           (accept),
    .sample_a       (s_tdata[RAW_W-1:0]),
    .sample_b       (s_tdata[2*RAW_W-1:RAW_W]),
    .sample_c       (s_tdata[3*RAW_W-1:2*RAW_W]),
    .use_median     (s_tdata[3*RAW_W]),
    .clear_rollover (s_tdata[3*RAW_W+1]),
    .cfg            (cfg),
    .item           (item)
  );

  gmat_scale u_scale (
    .clk      (clk),
    .load_mul (load_mul),
    .load_out (load_out),
    .item     (item),
    .cfg      (cfg),
    .result   (m_tdata)
  );

endmodule

// ----- rtl/gmat_checker.sv -----
// ---------------------------------------------------------------------------
// gmat_checker
// port-level checks on the tracker result stream
// ---------------------------------------------------------------------------
`include "geared_multiturn_angle_tracker_top_defines.svh"

module gmat_checker (
  input logic        clk,
  input logic        rst,
  input logic [79:0] m_tdata,
  input logic        m_tvalid,
  input logic        m_tready
);
  import gmat_pkg::*;

  logic [13:0] raw_f;
  logic [5:0]  turn_f;
  logic [19:0] ext_f;
  logic [1:0]  roll_f;
  logic        seen_f;
  logic        roll_ok;
  logic        ext_ok;

  // result fields from the lowest bit up
  assign raw_f  = m_tdata[13:0];
  assign turn_f = m_tdata[19:14];
  assign ext_f  = m_tdata[39:20];
  assign roll_f = m_tdata[76:75];
  assign seen_f = m_tdata[77];

  // legal rollover codes only
  assign roll_ok = (roll_f == ROLL_NONE) || (roll_f == ROLL_FWD) || (roll_f == ROLL_BWD);

  // extended count carries the raw angle and either the turn index or nothing
  assign ext_ok = (ext_f[13:0] == raw_f) && ((ext_f[19:14] == turn_f) || (ext_f[19:14] == '0));

  // result stays offered until taken
  `GMAT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped under stall")

  // rollover direction never the unused code
  `GMAT_ASSERT_NOW(a_roll_code, m_tvalid, roll_ok, "bad rollover code")

  // a rollover in this step shows in the sticky flag
  `GMAT_ASSERT_NOW(a_roll_sticky, m_tvalid && roll_f != ROLL_NONE, seen_f, "rollover not flagged")

  // extended count packing
  `GMAT_ASSERT_NOW(a_ext_pack, m_tvalid, ext_ok, "extended count mismatch")

endmodule

bind geared_multiturn_angle_tracker_top gmat_checker u_gmat_checker (.*);

// ----- test/tb_geared_multiturn_angle_tracker_top.sv -----
// ---------------------------------------------------------------------------
// tb_geared_multiturn_angle_tracker_top
// self-checking bench for the geared multi-turn angle tracker: a directed
// table of samples and register writes, then random encoder trajectories
// under a dozen register settings, each result compared field by field
// against literal values or an in-bench tracker model
// ---------------------------------------------------------------------------
module tb_geared_multiturn_angle_tracker_top;
  import gmat_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLD_CYCLES     = 250;
  localparam int HOLD_AFTER      = 520;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 155;

  // input transfer, first field in the highest bits
  typedef struct packed {
    logic [3:0]       pad;
    logic             clr;
    logic             med;
    logic [RAW_W-1:0] c;
    logic [RAW_W-1:0] b;
    logic [RAW_W-1:0] a;
  } sample_item_t;

  // output transfer, first field in the highest bits
  typedef struct packed {
    logic [1:0]         pad;
    logic               seen;
    logic [ROLL_W-1:0]  roll;
    logic [REL_W-1:0]   rel;
    logic [SHAFT_W-1:0] shaft;
    logic [EXT_W-1:0]   ext;
    logic [TURN_W-1:0]  turn;
    logic [RAW_W-1:0]   raw;
  } angle_result_t;

  // one row of the directed table: a register write or a sample item
  typedef struct {
    bit            is_cfg;
    cfg_idx_e      idx;
    int unsigned   val;
    sample_item_t  item;
    bit            lit;
    angle_result_t res;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // tracker model state and register copy
  cfg_regs_t         regs_q;
  logic [RAW_W-1:0]  prev_raw_q;
  logic [TURN_W-1:0] turn_q;
  logic              sticky_q;

  angle_result_t pending_angles[$];
  int error_count;
  int items_sent;
  int results_seen;
  int rollovers_seen;
  int settings_used;

  geared_multiturn_angle_tracker_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // tracker model: median select, rollover detect, turn count, scaling
  function automatic angle_result_t track_angle(sample_item_t it);
    logic [RAW_W-1:0] lo, hi, raw, prev;
    int               ratio, step, n, shaft, rel;
    longint unsigned  ext, scaled;
    angle_result_t    r;
    lo = (it.a < it.b) ? it.a : it.b;
    hi = (it.a < it.b) ? it.b : it.a;
    if (!it.med) raw = it.a;
    else if (it.c <= lo) raw = lo;
    else if (it.c >= hi) raw = hi;
    else raw = it.c;
    prev = prev_raw_q;
    prev_raw_q = raw;
    ratio = int'(regs_q.ratio);
    if (ratio == 0) ratio = 1;
    if (ratio > MAX_RATIO) ratio = MAX_RATIO;
    step = 0;
    if (ratio == 1) begin
      ext = longint'(raw);
      scaled = (longint'(raw) * 65536) / COUNTS_PER_TURN;
    end else begin
      // backward wins when both tests hold
      if (prev <= regs_q.lower && raw >= regs_q.upper) step = -1;
      else if (prev >= regs_q.upper && raw <= regs_q.lower) step = 1;
      if (step != 0) sticky_q = 1'b1;
      n = int'(turn_q) + step;
      if (n >= ratio) n = 0;
      else if (n < 0) n = ratio - 1;
      turn_q = n[TURN_W-1:0];
      ext = longint'(raw) + longint'(COUNTS_PER_TURN) * longint'(turn_q);
      scaled = (ext * longint'(regs_q.recip)) / COUNTS_PER_TURN;
    end
    if (scaled > 65535) scaled = 65535;
    shaft = int'(scaled) - int'(regs_q.shift);
    rel = shaft - int'(regs_q.zero);
    if (rel >= 32768) rel = rel - 65536;
    r       = '0;
    r.raw   = raw;
    r.turn  = turn_q;
    r.ext   = ext[EXT_W-1:0];
    r.shaft = shaft[SHAFT_W-1:0];
    r.rel   = rel[REL_W-1:0];
    r.roll  = (step < 0) ? ROLL_BWD : (step > 0) ? ROLL_FWD : ROLL_NONE;
    r.seen  = sticky_q;
    if (it.clr) sticky_q = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t item_row(int a, int b, int c, bit med, bit clr);
    dir_row_t r;
    r.is_cfg   = 1'b0;
    r.idx      = CFG_RATIO;
    r.val      = 0;
    r.item     = '0;
    r.item.a   = a[RAW_W-1:0];
    r.item.b   = b[RAW_W-1:0];
    r.item.c   = c[RAW_W-1:0];
    r.item.med = med;
    r.item.clr = clr;
    r.lit      = 1'b0;
    r.res      = '0;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(cfg_idx_e idx, int unsigned val);
    dir_row_t r;
    r = item_row(0, 0, 0, 1'b0, 1'b0);
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  // rows whose result is plain: bypass after reset, no turn, no rollover
  function automatic dir_row_t lit_row(int a, int b, int c, bit med,
                                       int raw, int shaft, int rel);
    dir_row_t r;
    r = item_row(a, b, c, med, 1'b0);
    r.lit       = 1'b1;
    r.res.raw   = raw[RAW_W-1:0];
    r.res.turn  = '0;
    r.res.ext   = EXT_W'(raw);
    r.res.shaft = shaft[SHAFT_W-1:0];
    r.res.rel   = rel[REL_W-1:0];
    r.res.roll  = ROLL_NONE;
    r.res.seen  = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned exp_v,
                                 longint unsigned got_v);
    $display("mismatch at result %0d, %s: expected %0h, got %0h",
             results_seen, what, exp_v, got_v);
    error_count++;
  endtask

  // register write, model copy follows at once (block is idle)
  task automatic set_register(cfg_idx_e idx, int unsigned value);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    case (idx)
      CFG_RATIO: regs_q.ratio = value[RATIO_W-1:0];
      CFG_RECIP: regs_q.recip = value[RECIP_W-1:0];
      CFG_LOWER: regs_q.lower = value[RAW_W-1:0];
      CFG_UPPER: regs_q.upper = value[RAW_W-1:0];
      CFG_SHIFT: regs_q.shift = value[OFFS_W-1:0];
      CFG_ZERO:  regs_q.zero  = value[OFFS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // drain every pending result, then let the pipeline settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // offer one item from a falling edge, predict on its transfer
  task automatic send_item(sample_item_t it, bit lit, angle_result_t lit_res);
    angle_result_t pred;
    s_tdata  <= it;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = track_angle(it);
    pending_angles.push_back(lit ? lit_res : pred);
    items_sent++;
    @(negedge clk);
  endtask

  // mostly short gaps, a few long ones
  task automatic sender_gap();
    int pick, len;
    pick = $urandom_range(0, 99);
    if (pick < 60) len = 0;
    else if (pick < 90) len = $urandom_range(1, 3);
    else len = $urandom_range(10, 40);
    if (len > 0) begin
      s_tvalid <= 1'b0;
      repeat (len) @(negedge clk);
    end
  endtask

  // result checking at the rising edge
  initial begin
    angle_result_t got, exp_r;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = angle_result_t'(m_tdata);
        if (pending_angles.size() == 0) begin
          report_mismatch("result with none pending", 0, m_tdata[63:0]);
        end else begin
          exp_r = pending_angles.pop_front();
          if (got.raw !== exp_r.raw) report_mismatch("raw_angle", exp_r.raw, got.raw);
          if (got.turn !== exp_r.turn) report_mismatch("turn_index", exp_r.turn, got.turn);
          if (got.ext !== exp_r.ext)
            report_mismatch("extended_count", exp_r.ext, got.ext);
          if (got.shaft !== exp_r.shaft)
            report_mismatch("shaft_angle", exp_r.shaft, got.shaft);
          if (got.rel !== exp_r.rel)
            report_mismatch("relative_angle", exp_r.rel, got.rel);
          if (got.roll !== exp_r.roll)
            report_mismatch("rollover_direction", exp_r.roll, got.roll);
          if (got.seen !== exp_r.seen)
            report_mismatch("rollover_seen", exp_r.seen, got.seen);
          if (exp_r.roll != ROLL_NONE) rollovers_seen++;
        end
        results_seen++;
      end
    end
  end

  // receiver: bursts of free flow, random stalls and long stalls, one long hold
  initial begin
    int  burst, mode, k;
    bit  held;
    held     = 1'b0;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      burst = $urandom_range(20, 150);
      mode  = $urandom_range(0, 3);
      for (k = 0; k < burst; k++) begin
        case (mode)
          2:       m_tready <= ($urandom_range(0, 99) < 65);
          3:       m_tready <= (k >= burst / 4);
          default: m_tready <= 1'b1;
        endcase
        @(negedge clk);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // stimulus
  initial begin
    dir_row_t     dir_q[$];
    sample_item_t it;
    int           phase, k, angle, vel, step;
    int unsigned  ratio, recip, lower, upper, shift, zero;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_wr_en = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    error_count    = 0;
    items_sent     = 0;
    results_seen   = 0;
    rollovers_seen = 0;
    settings_used  = 1;
    regs_q.ratio = RATIO_RST;
    regs_q.recip = RECIP_RST;
    regs_q.lower = LOWER_RST;
    regs_q.upper = UPPER_RST;
    regs_q.shift = '0;
    regs_q.zero  = '0;
    prev_raw_q = '0;
    turn_q     = '0;
    sticky_q   = 1'b0;

    // directed table, reset settings first: bypass, median select
    dir_q.push_back(lit_row(0, 0, 0, 1'b0, 0, 0, 0));
    dir_q.push_back(lit_row(16383, 0, 0, 1'b0, 16383, 65532, -4));
    dir_q.push_back(lit_row(16383, 0, 8000, 1'b1, 8000, 32000, 32000));
    dir_q.push_back(lit_row(0, 16383, 16383, 1'b1, 16383, 65532, -4));
    // counting with ratio four: forward, backward, sticky clear, limits
    dir_q.push_back(cfg_row(CFG_RATIO, 4));
    dir_q.push_back(cfg_row(CFG_RECIP, 16384));
    dir_q.push_back(item_row(100, 16383, 16383, 1'b0, 1'b0));
    dir_q.push_back(item_row(16000, 0, 0, 1'b0, 1'b0));
    dir_q.push_back(item_row(16000, 0, 0, 1'b0, 1'b1));
    dir_q.push_back(item_row(16000, 0, 0, 1'b0, 1'b0));
    dir_q.push_back(item_row(0, 0, 0, 1'b0, 1'b0));
    dir_q.push_back(item_row(12288, 0, 0, 1'b0, 1'b0));
    dir_q.push_back(item_row(4096, 0, 0, 1'b0, 1'b0));
    dir_q.push_back(item_row(16383, 0, 0, 1'b0, 1'b0));
    // backward wrap from zero to ratio minus one, forward wrap back to zero
    dir_q.push_back(item_row(1000, 0, 0, 1'b0, 1'b0));
    dir_q.push_back(item_row(15000, 0, 0, 1'b0, 1'b0));
    dir_q.push_back(item_row(8000, 0, 0, 1'b0, 1'b0));
    dir_q.push_back(item_row(2000, 0, 0, 1'b0, 1'b0));
    dir_q.push_back(item_row(14000, 0, 0, 1'b0, 1'b0));
    dir_q.push_back(item_row(1000, 0, 0, 1'b0, 1'b0));
    // counter left too large by a lowered ratio
    dir_q.push_back(item_row(8000, 0, 0, 1'b0, 1'b0));
    dir_q.push_back(item_row(1000, 0, 0, 1'b0, 1'b0));
    dir_q.push_back(item_row(14000, 0, 0, 1'b0, 1'b0));
    dir_q.push_back(cfg_row(CFG_RATIO, 2));
    dir_q.push_back(cfg_row(CFG_RECIP, 32768));
    dir_q.push_back(item_row(14000, 0, 0, 1'b0, 1'b0));
    // overlapping limits: both tests hold, backward has priority
    dir_q.push_back(cfg_row(CFG_LOWER, 12000));
    dir_q.push_back(cfg_row(CFG_UPPER, 4000));
    dir_q.push_back(item_row(5000, 0, 0, 1'b0, 1'b0));
    dir_q.push_back(item_row(6000, 0, 0, 1'b0, 1'b0));
    // ratio above the maximum with an oversized reciprocal saturates
    dir_q.push_back(cfg_row(CFG_LOWER, 4096));
    dir_q.push_back(cfg_row(CFG_UPPER, 12288));
    dir_q.push_back(cfg_row(CFG_RATIO, 127));
    dir_q.push_back(cfg_row(CFG_RECIP, 131071));
    dir_q.push_back(item_row(16383, 16383, 16383, 1'b1, 1'b0));
    // ratio zero is bypass; largest offsets give the lowest relative angle
    dir_q.push_back(cfg_row(CFG_RATIO, 0));
    dir_q.push_back(cfg_row(CFG_SHIFT, 65535));
    dir_q.push_back(cfg_row(CFG_ZERO, 65535));
    dir_q.push_back(item_row(0, 5, 9, 1'b0, 1'b0));

    // reset
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_q[i]) begin
      if (dir_q[i].is_cfg) begin
        wait_idle();
        set_register(dir_q[i].idx, dir_q[i].val);
        settings_used++;
      end else begin
        send_item(dir_q[i].item, dir_q[i].lit, dir_q[i].res);
        sender_gap();
      end
    end

    // random phases, one register setting each
    angle = 0;
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      lower = LOWER_RST;
      upper = UPPER_RST;
      shift = 0;
      zero  = 0;
      case (phase)
        0: begin ratio = 64;  recip = 1024; end
        1: begin ratio = 1;   recip = 65536; shift = 65535; end
        2: begin ratio = 0;   recip = 65536; zero = 65535; end
        3: begin
          ratio = 127; recip = 131071; lower = 0; upper = 16383;
          shift = 65535; zero = 65535;
        end
        4: begin
          ratio = 2; recip = 32768; lower = 16383; upper = 0;
          shift = 32768; zero = 32768;
        end
        5: begin ratio = 64;  recip = 0; lower = 8191; upper = 8192; end
        default: begin
          ratio = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                              : $urandom_range(2, 64);
          if ($urandom_range(0, 9) == 0 || ratio == 0) recip = $urandom_range(0, 131071);
          else recip = (65536 + ratio / 2) / ratio;
          lower = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16383)
                                              : $urandom_range(500, 6000);
          upper = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16383)
                                              : $urandom_range(10000, 15800);
          shift = $urandom_range(0, 65535);
          zero  = $urandom_range(0, 65535);
        end
      endcase
      set_register(CFG_RATIO, ratio);
      set_register(CFG_RECIP, recip);
      set_register(CFG_LOWER, lower);
      set_register(CFG_UPPER, upper);
      set_register(CFG_SHIFT, shift);
      set_register(CFG_ZERO, zero);
      settings_used++;
      vel = int'($urandom_range(0, 3000)) - 1500;

      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        it = '0;
        if ($urandom_range(0, 99) < 15) begin
          // noise: any field value
          it.a   = RAW_W'($urandom);
          it.b   = RAW_W'($urandom);
          it.c   = RAW_W'($urandom);
          it.med = 1'($urandom);
          it.clr = 1'($urandom);
        end else begin
          // encoder trajectory with jitter, rare jumps and outliers
          step = vel + int'($urandom_range(0, 600)) - 300;
          if ($urandom_range(0, 99) < 5) step = $urandom_range(0, 16383);
          angle = (angle + step) & 16383;
          it.a = RAW_W'(angle + int'($urandom_range(0, 40)) - 20);
          it.b = RAW_W'(angle + int'($urandom_range(0, 40)) - 20);
          it.c = RAW_W'(angle + int'($urandom_range(0, 40)) - 20);
          if ($urandom_range(0, 9) == 0) it.b = RAW_W'($urandom);
          it.med = ($urandom_range(0, 99) < 80);
          it.clr = ($urandom_range(0, 9) == 0);
        end
        send_item(it, 1'b0, '0);
        if (phase % 3 != 0) sender_gap();
      end
    end

    // drain and settle
    s_tvalid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_angles.size() != 0)
      report_mismatch("results still pending", 0, pending_angles.size());

    $display("%0d sample items over %0d register settings, %0d results checked",
             items_sent, settings_used, results_seen);
    $display("ratios from bypass to saturation, extreme wrap limits, %0d rollovers",
             rollovers_seen);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
